### sv/cad_pkg.sv
package cad_pkg;

    // Alphabet capacity; the position field is 7 bits, so the count tops out at 127.
    localparam int KEY_DEPTH = 128;
    localparam int CAP_INT   = (KEY_DEPTH < 127) ? KEY_DEPTH : 127;

    localparam int CHAR_W  = 7;
    localparam int COUNT_W = 7;
    localparam int SEED_W  = 4;

    localparam logic [COUNT_W-1:0] CAP        = COUNT_W'(CAP_INT);
    localparam logic [SEED_W-1:0]  SEED_RESET = SEED_W'(8);

    // Seen-map: 128 bits held as rows of 8 bits
    localparam int BIT_AW = 3;
    localparam int ROW_W  = 1 << BIT_AW;
    localparam int ROW_AW = CHAR_W - BIT_AW;
    localparam int ROWS   = 1 << ROW_AW;

    typedef enum logic [1:0] {
        MODE_SEED  = 2'd0,
        MODE_ALPHA = 2'd1,
        MODE_END   = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_REJECT   = 3'd1,
        ST_FULL     = 3'd2,
        ST_INCOMP   = 3'd3,
        ST_SHORT    = 3'd4,
        ST_OK       = 3'd5
    } status_t;

    typedef struct packed {
        logic              printable;
        logic [CHAR_W-1:0] code;
    } fold_t;

    typedef struct packed {
        logic              we;
        logic [ROW_AW-1:0] addr;
        logic [ROW_W-1:0]  data;
    } mem_wr_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] position;
        logic [CHAR_W-1:0]  out_char;
    } result_t;

    // Fold lowercase to uppercase, then test for 0x20..0x7E.
    function automatic fold_t fold_char(input logic [7:0] raw);
        fold_t      f;
        logic [7:0] c;
        begin
            c = raw;
            if (raw >= 8'h61 && raw <= 8'h7A)
            begin
                c = raw - 8'h20;
            end
            f.printable = (c >= 8'h20) && (c <= 8'h7E);
            f.code      = c[CHAR_W-1:0];
            return f;
        end
    endfunction

endpackage

### sv/cad_seen_mem.sv
module cad_seen_mem (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [cad_pkg::ROW_AW-1:0]   rd_addr,
    output logic [cad_pkg::ROW_W-1:0]    rd_data,
    input  cad_pkg::mem_wr_t             wr
);

    logic [cad_pkg::ROW_W-1:0] mem [cad_pkg::ROWS];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read before write: a same-row write in this cycle is forwarded by the core
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/cad_core.sv
module cad_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cad_pkg::SEED_W-1:0]    cfg_wdata,
    input  logic                          accept,
    input  cad_pkg::mode_t                in_mode,
    input  cad_pkg::fold_t                in_fold,
    input  logic                          adv,
    input  logic [cad_pkg::ROW_W-1:0]     rd_data,
    output logic                          busy,
    output logic                          fire,
    output cad_pkg::result_t              result,
    output cad_pkg::mem_wr_t              wr
);

    logic                           s1_valid_reg, s1_valid_next;
    cad_pkg::mode_t                 s1_mode_reg;
    cad_pkg::fold_t                 s1_fold_reg;
    logic [cad_pkg::SEED_W-1:0]     seed_reg, seed_next;
    logic [cad_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [cad_pkg::ROWS-1:0]       row_valid_reg, row_valid_next;
    logic                           fwd_hit_reg, fwd_hit_next;
    logic [cad_pkg::ROW_W-1:0]      fwd_data_reg;

    logic [cad_pkg::ROW_AW-1:0]     row;
    logic [cad_pkg::BIT_AW-1:0]     bit_sel;
    logic [cad_pkg::ROW_W-1:0]      row_word;
    logic                           seen;
    logic                           seed_done;
    cad_pkg::status_t               try_status;
    cad_pkg::status_t               status;

    assign row     = s1_fold_reg.code[cad_pkg::CHAR_W-1:cad_pkg::BIT_AW];
    assign bit_sel = s1_fold_reg.code[cad_pkg::BIT_AW-1:0];

    // Rows never written since reset or clear read as zero; forward the last write
    always_comb
    begin
        if (!row_valid_reg[row])
        begin
            row_word = '0;
        end
        else if (fwd_hit_reg)
        begin
            row_word = fwd_data_reg;
        end
        else
        begin
            row_word = rd_data;
        end
    end

    assign seen      = row_word[bit_sel];
    assign seed_done = count_reg >= {{(cad_pkg::COUNT_W - cad_pkg::SEED_W){1'b0}}, seed_reg};

    always_comb
    begin
        if (!s1_fold_reg.printable || seen)
        begin
            try_status = cad_pkg::ST_REJECT;
        end
        else if (count_reg >= cad_pkg::CAP)
        begin
            try_status = cad_pkg::ST_FULL;
        end
        else
        begin
            try_status = cad_pkg::ST_APPENDED;
        end

        case (s1_mode_reg)
            cad_pkg::MODE_SEED:  status = seed_done ? cad_pkg::ST_FULL : try_status;
            cad_pkg::MODE_ALPHA: status = seed_done ? try_status : cad_pkg::ST_INCOMP;
            cad_pkg::MODE_END:   status = seed_done ? cad_pkg::ST_OK : cad_pkg::ST_SHORT;
            default:             status = cad_pkg::ST_OK;
        endcase
    end

    assign busy = s1_valid_reg;
    assign fire = s1_valid_reg && adv;

    always_comb
    begin
        result.status   = status;
        result.out_char = (status == cad_pkg::ST_APPENDED) ? s1_fold_reg.code : '0;
        result.position = (status == cad_pkg::ST_APPENDED) ? count_reg : '0;

        wr.we   = fire && (status == cad_pkg::ST_APPENDED);
        wr.addr = row;
        wr.data = row_word | (cad_pkg::ROW_W'(1) << bit_sel);
    end

    always_comb
    begin
        seed_next      = cfg_we ? cfg_wdata : seed_reg;
        count_next     = count_reg;
        row_valid_next = row_valid_reg;
        if (fire && s1_mode_reg == cad_pkg::MODE_CLEAR)
        begin
            count_next     = '0;
            row_valid_next = '0;
        end
        else if (wr.we)
        begin
            count_next          = count_reg + cad_pkg::COUNT_W'(1);
            row_valid_next[row] = 1'b1;
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        fwd_hit_next = fwd_hit_reg;
        if (accept)
        begin
            fwd_hit_next = wr.we &&
                (wr.addr == in_fold.code[cad_pkg::CHAR_W-1:cad_pkg::BIT_AW]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            seed_reg      <= cad_pkg::SEED_RESET;
            count_reg     <= '0;
            row_valid_reg <= '0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            seed_reg      <= seed_next;
            count_reg     <= count_next;
            row_valid_reg <= row_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg  <= in_mode;
            s1_fold_reg  <= in_fold;
            fwd_data_reg <= wr.data;
        end
    end

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cad_pkg::CAP)
        else $error("alphabet count beyond capacity");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_mode_reg == cad_pkg::MODE_CLEAR) |=> (count_reg == '0 && row_valid_reg == '0))
        else $error("clear left state behind");

    a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |=> (count_reg == $past(count_reg) + cad_pkg::COUNT_W'(1)))
        else $error("append did not advance count");

    a_write_marks_row: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |=> row_valid_reg[$past(row)])
        else $error("written row not marked valid");
`endif

endmodule

### sv/checkerboard_alphabet_dedup_top.sv
// Channel  | Signals                          | Word layout (low bit first)
// ---------+----------------------------------+-------------------------------------------
// input    | s_axis_tvalid/tready/tdata/tuser | tdata: in_byte[7:0]; tuser: mode[1:0]
// output   | m_axis_tvalid/tready/tdata       | tdata: out_char[6:0] position[13:7]
//          |                                  |        status[16:14], zero pad [23:17]
// config   | cfg_we, cfg_wdata                | cfg_wdata: seed_count[3:0]
//
// One word per cycle sustained while the output is not stalled; each word passes from accept
// to result through the seen-map row read, then test, update and result register.
// The seen-map row read-modify-write is the loop; a write to the row the next word
// reads is forwarded, so back-to-back words on the same row need no bubble.
// Reset clears the count and the row valid bits at once; no clearing pass.
// A stalled output holds the result register and stops new words only once
// the decision stage is also full.
module checkerboard_alphabet_dedup_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,      // seed_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // out_char[6:0], position[13:7], status[16:14]
);

    logic                          accept;
    logic                          adv;
    logic                          busy;
    logic                          fire;
    cad_pkg::fold_t                in_fold;
    cad_pkg::mode_t                in_mode;
    cad_pkg::result_t              result;
    cad_pkg::mem_wr_t              wr;
    logic [cad_pkg::ROW_W-1:0]     rd_data;

    logic                          m_valid_reg, m_valid_next;
    logic [23:0]                   m_data_reg;

    // Fold and classify the incoming byte before the row read
    assign in_fold = cad_pkg::fold_char(s_axis_tdata);
    assign in_mode = cad_pkg::mode_t'(s_axis_tuser);

    // Decision stage advances when the output register is free or being drained
    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !busy || adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cad_seen_mem u_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (in_fold.code[cad_pkg::CHAR_W-1:cad_pkg::BIT_AW]),
        .rd_data (rd_data),
        .wr      (wr)
    );

    cad_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_mode   (in_mode),
        .in_fold   (in_fold),
        .adv       (adv),
        .rd_data   (rd_data),
        .busy      (busy),
        .fire      (fire),
        .result    (result),
        .wr        (wr)
    );

    // Output register: load on fire, drop when taken
    always_comb
    begin
        if (fire)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            m_data_reg <= {7'b0, result.status, result.position, result.out_char};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
